// ===== hdl/fpmc_pkg.sv =====
`timescale 1ns / 1ps

package fpmc_pkg;

    // Mode counts of the three selectors.
    localparam logic [6:0] PROGRAM_COUNT    = 7'd8;
    localparam logic [6:0] COLOR_MODE_COUNT = 7'd8;
    localparam logic [6:0] EFFECT_COUNT     = 7'd4;

    // Reset values of the configuration registers.
    localparam logic [11:0] THRESHOLD_RESET    = 12'd123;
    localparam logic [15:0] DEFAULT_HOLD_RESET = 16'd8000;
    localparam logic [15:0] PALETTE_HOLD_RESET = 16'd9000;
    localparam logic [15:0] FADE_IN_RESET      = 16'd1000;
    localparam logic [15:0] FADE_OUT_RESET     = 16'd1500;
    localparam logic [31:0] PERSIST_RESET      = 32'd10000;

    localparam logic [11:0] KNOB_RESET = 12'd4095;
    localparam logic [7:0]  LEVEL_FULL = 8'd255;

    // Event codes carried with each input transaction.
    typedef enum logic [2:0] {
        ACT_TICK        = 3'd0,
        ACT_PROG_ENC    = 3'd1,
        ACT_PROG_BUTTON = 3'd2,
        ACT_COLOR_ENC   = 3'd3,
        ACT_COLOR_BUTTON = 3'd4,
        ACT_SPEED_KNOB  = 3'd5,
        ACT_BRIGHT_KNOB = 3'd6
    } action_t;

    // Display selection codes.
    typedef enum logic [1:0] {
        DISP_PREVIEW = 2'd0,
        DISP_PALETTE = 2'd1,
        DISP_BRIGHT  = 2'd2,
        DISP_SPEED   = 2'd3
    } display_t;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_THRESHOLD    = 3'd0,
        REG_DEFAULT_HOLD = 3'd1,
        REG_PALETTE_HOLD = 3'd2,
        REG_FADE_IN      = 3'd3,
        REG_FADE_OUT     = 3'd4,
        REG_PERSIST      = 3'd5
    } reg_index_t;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_EVENT   = 6'b000010,
        ST_TIMEOUT = 6'b000100,
        ST_FADE    = 6'b001000,
        ST_DIV     = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    // Configuration values as seen by the datapath.
    typedef struct packed {
        logic [11:0] change_threshold;
        logic [15:0] default_hold_ms;
        logic [15:0] palette_hold_ms;
        logic [15:0] fade_in_ms;
        logic [15:0] fade_out_ms;
        logic [31:0] persist_interval_ms;
    } cfg_t;

    // Divider handshake.
    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } div_rsp_t;

endpackage

// ===== hdl/fpmc_cfg.sv =====
`timescale 1ns / 1ps

module fpmc_cfg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output fpmc_pkg::cfg_t cfg
);
    import fpmc_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes complete in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.change_threshold    <= THRESHOLD_RESET;
            cfg_reg.default_hold_ms     <= DEFAULT_HOLD_RESET;
            cfg_reg.palette_hold_ms     <= PALETTE_HOLD_RESET;
            cfg_reg.fade_in_ms          <= FADE_IN_RESET;
            cfg_reg.fade_out_ms         <= FADE_OUT_RESET;
            cfg_reg.persist_interval_ms <= PERSIST_RESET;
        end else if (wr_en) begin
            case (index)
                REG_THRESHOLD:    cfg_reg.change_threshold    <= pwdata[11:0];
                REG_DEFAULT_HOLD: cfg_reg.default_hold_ms     <= pwdata[15:0];
                REG_PALETTE_HOLD: cfg_reg.palette_hold_ms     <= pwdata[15:0];
                REG_FADE_IN:      cfg_reg.fade_in_ms          <= pwdata[15:0];
                REG_FADE_OUT:     cfg_reg.fade_out_ms         <= pwdata[15:0];
                REG_PERSIST:      cfg_reg.persist_interval_ms <= pwdata;
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (index)
            REG_THRESHOLD:    prdata = {20'd0, cfg_reg.change_threshold};
            REG_DEFAULT_HOLD: prdata = {16'd0, cfg_reg.default_hold_ms};
            REG_PALETTE_HOLD: prdata = {16'd0, cfg_reg.palette_hold_ms};
            REG_FADE_IN:      prdata = {16'd0, cfg_reg.fade_in_ms};
            REG_FADE_OUT:     prdata = {16'd0, cfg_reg.fade_out_ms};
            REG_PERSIST:      prdata = cfg_reg.persist_interval_ms;
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/fpmc_div.sv =====
`timescale 1ns / 1ps

module fpmc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  fpmc_pkg::div_req_t req,
    output fpmc_pkg::div_rsp_t rsp
);
    import fpmc_pkg::*;

    // The caller guarantees dividend < divisor * 256, so the quotient fits
    // in eight bits and the upper dividend bits start as the partial remainder.
    logic [15:0] rem_reg,  rem_next;
    logic [7:0]  dvd_reg,  dvd_next;
    logic [7:0]  quo_reg,  quo_next;
    logic [2:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [15:0] div_reg,  div_next;
    logic [16:0] trial;
    logic        fits;

    // One restoring step: shift in a dividend bit, compare, subtract.
    assign trial = {rem_reg, dvd_reg[7]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.dividend[23:8];
            dvd_next  = req.dividend[7:0];
            div_next  = req.divisor;
            quo_next  = 8'd0;
            cnt_next  = 3'd7;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
            dvd_next = {dvd_reg[6:0], 1'b0};
            quo_next = {quo_reg[6:0], fits};
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/front_panel_mode_controller.sv =====
`timescale 1ns / 1ps
// Front panel mode controller.
// Input stream: one transaction per front-panel event or timer tick. tuser
// carries the event code, tdata the millisecond timestamp, the encoder pins
// and the knob sample. Every input transaction yields exactly one output
// transaction with the selected display, its fade level, the three mode
// indexes, the accepted knob values and a persist request flag.
// Configuration registers sit on the APB-style port at byte addresses 4*i.
// Processing: an item walks through event, timeout and fade steps; when the
// fade level lies inside its window an 8-step restoring divider runs before
// the result is loaded into the output register. One item is in work at a
// time, so a new item is taken only once the previous one has been loaded
// into the output register.
// s_tready is high while the sequencer is idle, also while a result waits
// in the output register. If the receiver stalls, a finished item waits
// for the output register to free up, and no new item is taken meanwhile.
// Synchronous reset restores every mode, knob level, display, expiry and
// persist time and configuration register, and empties the output register.

module front_panel_mode_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // now_ms[31:0], pin_a, pin_b, knob_sample[11:0], zero pad
    input  logic [2:0]  s_tuser,  // action[2:0]
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // shown_display[1:0], fade_level[7:0], program_index[5:0],
                                  // color_index[5:0], effect_index[5:0], speed_code[11:0],
                                  // brightness_code[11:0], persist_request, zero pad
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fpmc_pkg::*;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t      state_reg, state_next;

    // Latched input transaction
    action_t     act_reg;
    logic [31:0] now_reg;
    logic        pa_reg, pb_reg;
    logic [11:0] ks_reg;

    // Architectural state
    logic        prog_a_reg, prog_a_next, prog_b_reg, prog_b_next;
    logic        color_a_reg, color_a_next, color_b_reg, color_b_next;
    logic [5:0]  program_reg, program_next;
    logic [5:0]  color_reg, color_next;
    logic [5:0]  effect_reg, effect_next;
    logic [11:0] speed_reg, speed_next;
    logic [11:0] bright_reg, bright_next;
    display_t    disp_reg, disp_next;
    logic [31:0] expire_reg, expire_next;
    logic        pending_reg, pending_next;
    logic [31:0] last_persist_reg, last_persist_next;

    // Per-item results
    logic [7:0]  level_reg, level_next;
    logic        req_reg, req_next;

    // Output register
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic        out_load;

    // Event decode helpers
    logic        enc_a_last, enc_b_last;
    logic        step_up, step_down;
    logic [6:0]  mode_count;
    logic [5:0]  mode_cur;
    logic [11:0] knob_level, knob_diff;
    logic        knob_change;

    // Timeout, fade and persist helpers
    logic [31:0] since_expire, fade_t, since_persist;
    logic [15:0] fade_win;
    logic        in_window;

    fpmc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpmc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Quadrature decode against the stored pin levels of the addressed encoder.
    assign enc_a_last = (act_reg == ACT_COLOR_ENC) ? color_a_reg : prog_a_reg;
    assign enc_b_last = (act_reg == ACT_COLOR_ENC) ? color_b_reg : prog_b_reg;
    assign step_up    = !pa_reg && enc_a_last && !pb_reg && !enc_b_last;
    assign step_down  = !pa_reg && !enc_a_last && !pb_reg && enc_b_last;
    assign mode_count = (act_reg == ACT_COLOR_ENC) ? COLOR_MODE_COUNT : PROGRAM_COUNT;
    assign mode_cur   = (act_reg == ACT_COLOR_ENC) ? color_reg : program_reg;

    // Knob change detection against the addressed level.
    assign knob_level  = (act_reg == ACT_SPEED_KNOB) ? speed_reg : bright_reg;
    assign knob_diff   = (ks_reg > knob_level) ? ks_reg - knob_level : knob_level - ks_reg;
    assign knob_change = knob_diff > cfg.change_threshold;

    // Elapsed times in modular millisecond arithmetic.
    assign since_expire  = now_reg - expire_reg;
    assign since_persist = now_reg - last_persist_reg;
    assign fade_t        = (disp_reg != DISP_PREVIEW) ? expire_reg - now_reg : since_expire;
    assign fade_win      = (disp_reg != DISP_PREVIEW) ? cfg.fade_out_ms : cfg.fade_in_ms;
    assign in_window     = (fade_win != 16'd0) && (fade_t < {16'd0, fade_win});

    // Divider request: fade_t * 255 as a shift and subtract.
    assign div_req.start    = (state_reg == ST_FADE) && in_window;
    assign div_req.dividend = {fade_t[15:0], 8'd0} - {8'd0, fade_t[15:0]};
    assign div_req.divisor  = fade_win;

    // Sequencer and state update.
    always_comb begin
        state_next        = state_reg;
        prog_a_next       = prog_a_reg;
        prog_b_next       = prog_b_reg;
        color_a_next      = color_a_reg;
        color_b_next      = color_b_reg;
        program_next      = program_reg;
        color_next        = color_reg;
        effect_next       = effect_reg;
        speed_next        = speed_reg;
        bright_next       = bright_reg;
        disp_next         = disp_reg;
        expire_next       = expire_reg;
        pending_next      = pending_reg;
        last_persist_next = last_persist_reg;
        level_next        = level_reg;
        req_next          = req_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EVENT;
                end
            end

            ST_EVENT: begin
                state_next = ST_TIMEOUT;
                case (act_reg)
                    ACT_PROG_ENC, ACT_COLOR_ENC: begin
                        if (step_up && ({1'b0, mode_cur} + 7'd1 < mode_count)) begin
                            pending_next = 1'b1;
                            if (act_reg == ACT_COLOR_ENC) begin
                                color_next = mode_cur + 6'd1;
                            end else begin
                                program_next = mode_cur + 6'd1;
                            end
                        end else if (step_down && (mode_cur != 6'd0)) begin
                            pending_next = 1'b1;
                            if (act_reg == ACT_COLOR_ENC) begin
                                color_next = mode_cur - 6'd1;
                            end else begin
                                program_next = mode_cur - 6'd1;
                            end
                        end
                        if (act_reg == ACT_COLOR_ENC) begin
                            color_a_next = pa_reg;
                            color_b_next = pb_reg;
                            disp_next    = DISP_PALETTE;
                            expire_next  = now_reg + {16'd0, cfg.palette_hold_ms};
                        end else begin
                            prog_a_next = pa_reg;
                            prog_b_next = pb_reg;
                            disp_next   = DISP_PREVIEW;
                            expire_next = 32'd0;
                        end
                    end
                    ACT_PROG_BUTTON: begin
                        if ({1'b0, effect_reg} + 7'd1 < EFFECT_COUNT) begin
                            effect_next = effect_reg + 6'd1;
                        end else begin
                            effect_next = 6'd0;
                        end
                        pending_next = 1'b1;
                    end
                    ACT_COLOR_BUTTON: begin
                        color_next  = 6'd0;
                        disp_next   = DISP_PREVIEW;
                        expire_next = 32'd0;
                    end
                    ACT_SPEED_KNOB, ACT_BRIGHT_KNOB: begin
                        if (knob_change) begin
                            expire_next = now_reg + {16'd0, cfg.default_hold_ms};
                            if (act_reg == ACT_SPEED_KNOB) begin
                                speed_next = ks_reg;
                                disp_next  = DISP_SPEED;
                            end else begin
                                bright_next = ks_reg;
                                disp_next   = DISP_BRIGHT;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            ST_TIMEOUT: begin
                // An expired display falls back to the preview; the expiry
                // time is kept so the preview fades in from it.
                state_next = ST_FADE;
                if ((since_expire != 32'd0) && !since_expire[31]) begin
                    disp_next = DISP_PREVIEW;
                end
                // Rate-limited persist request.
                req_next = 1'b0;
                if (pending_reg && (since_persist > cfg.persist_interval_ms)) begin
                    pending_next      = 1'b0;
                    last_persist_next = now_reg;
                    req_next          = 1'b1;
                end
            end

            ST_FADE: begin
                if (in_window) begin
                    state_next = ST_DIV;
                end else begin
                    level_next = LEVEL_FULL;
                    state_next = ST_DONE;
                end
            end

            ST_DIV: begin
                if (div_rsp.done) begin
                    level_next = div_rsp.quotient;
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control and architectural state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            prog_a_reg       <= 1'b0;
            prog_b_reg       <= 1'b0;
            color_a_reg      <= 1'b0;
            color_b_reg      <= 1'b0;
            program_reg      <= 6'd0;
            color_reg        <= 6'd0;
            effect_reg       <= 6'd0;
            speed_reg        <= KNOB_RESET;
            bright_reg       <= KNOB_RESET;
            disp_reg         <= DISP_PREVIEW;
            expire_reg       <= 32'd0;
            pending_reg      <= 1'b0;
            last_persist_reg <= 32'd0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            prog_a_reg       <= prog_a_next;
            prog_b_reg       <= prog_b_next;
            color_a_reg      <= color_a_next;
            color_b_reg      <= color_b_next;
            program_reg      <= program_next;
            color_reg        <= color_next;
            effect_reg       <= effect_next;
            speed_reg        <= speed_next;
            bright_reg       <= bright_next;
            disp_reg         <= disp_next;
            expire_reg       <= expire_next;
            pending_reg      <= pending_next;
            last_persist_reg <= last_persist_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the latched item, per-item results and output data.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg <= action_t'(s_tuser);
            now_reg <= s_tdata[31:0];
            pa_reg  <= s_tdata[32];
            pb_reg  <= s_tdata[33];
            ks_reg  <= s_tdata[45:34];
        end
        level_reg <= level_next;
        req_reg   <= req_next;
        if (out_load) begin
            m_tdata_reg <= {3'd0, req_reg, bright_reg, speed_reg, effect_reg,
                            color_reg, program_reg, level_reg, disp_reg};
        end
    end

    // The quotient of a fade inside its window never reaches full level.
    a_div_below_full: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> div_rsp.quotient != LEVEL_FULL)
        else $error("fade quotient reached full level inside the window");

    // The divider reports only while the sequencer waits for it.
    a_div_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the division step");

    // A delivered persist request leaves nothing pending.
    a_persist_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && req_reg) |-> !pending_reg)
        else $error("persist request issued while a save is still pending");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fpmc_pkg::*;

    // Event code outside the defined set; the block treats it like a tick.
    localparam logic [2:0] ACT_SPARE = 3'd7;

    // Encoder pin sequences as {a, b}; each one ends on the transition
    // that the decoder counts as a step.
    localparam logic [7:0] TURN_UP   = 8'b01_11_10_00;
    localparam logic [7:0] TURN_DOWN = 8'b10_11_01_00;

    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int BACKLOG_CYCLES = 300;
    localparam int PHASE_ITEMS    = 250;

    // Input transaction payload, last field in the lowest bits.
    typedef struct packed {
        logic [11:0] knob_sample;
        logic        pin_b;
        logic        pin_a;
        logic [31:0] now_ms;
    } panel_event_t;

    // Output transaction payload, last field in the lowest bits.
    typedef struct packed {
        logic        persist_request;
        logic [11:0] brightness_code;
        logic [11:0] speed_code;
        logic [5:0]  effect_index;
        logic [5:0]  color_index;
        logic [5:0]  program_index;
        logic [7:0]  fade_level;
        logic [1:0]  shown_display;
    } panel_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;  // now_ms[31:0], pin_a, pin_b, knob_sample[11:0], zero pad
    logic [2:0]  s_tuser  = '0;  // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // shown_display[1:0], fade_level[7:0], program_index[5:0],
                                 // color_index[5:0], effect_index[5:0], speed_code[11:0],
                                 // brightness_code[11:0], persist_request, zero pad
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    front_panel_mode_controller u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicted panel state, starting from the reset values.
    cfg_t panel_cfg = '{THRESHOLD_RESET, DEFAULT_HOLD_RESET, PALETTE_HOLD_RESET,
                        FADE_IN_RESET, FADE_OUT_RESET, PERSIST_RESET};
    logic [1:0]  prog_pins    = 2'b00;
    logic [1:0]  color_pins   = 2'b00;
    logic [5:0]  program_mode = '0;
    logic [5:0]  color_mode   = '0;
    logic [5:0]  effect_mode  = '0;
    logic [11:0] speed_lvl    = KNOB_RESET;
    logic [11:0] bright_lvl   = KNOB_RESET;
    display_t    shown        = DISP_PREVIEW;
    logic [31:0] expire_at    = '0;
    logic        persist_due  = 1'b0;
    logic [31:0] saved_at     = '0;

    panel_result_t expected_results[$];
    panel_result_t observed;
    panel_result_t predicted;
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    int            hold_len = 0;
    bit            steady = 1'b0;
    logic [31:0]   clock_ms = '0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Moves the running millisecond stamp forward by a random amount.
    function automatic logic [31:0] advance_clock();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) clock_ms = clock_ms;
        else if (roll < 65) clock_ms = clock_ms + $urandom_range(1, 400);
        else if (roll < 90) clock_ms = clock_ms + $urandom_range(400, 12000);
        else if (roll < 97) clock_ms = clock_ms + $urandom_range(12000, 70000);
        else clock_ms = clock_ms + $urandom;
        return clock_ms;
    endfunction

    // Quadrature decode: +1 for a step up, -1 for a step down.
    function automatic int quad_dir(logic [1:0] prev, logic [1:0] pins);
        if (pins == 2'b00 && prev == 2'b10) return 1;
        if (pins == 2'b00 && prev == 2'b01) return -1;
        return 0;
    endfunction

    // Saturating mode step; a step that moves the mode marks settings dirty.
    function automatic logic [5:0] step_mode(logic [5:0] m, logic [6:0] count, int dir);
        if (dir > 0 && ({1'b0, m} + 7'd1) < count) begin
            persist_due = 1'b1;
            return m + 6'd1;
        end
        if (dir < 0 && m != 6'd0) begin
            persist_due = 1'b1;
            return m - 6'd1;
        end
        return m;
    endfunction

    // Computes the result of one front-panel event and updates the state.
    function automatic panel_result_t predict_panel(logic [2:0] act, logic [31:0] now,
                                                    logic pa, logic pb, logic [11:0] ks);
        panel_result_t r;
        logic [31:0]   since;
        logic [31:0]   span;
        logic [15:0]   win;
        logic [11:0]   cur;
        logic [11:0]   diff;
        logic [63:0]   scaled;
        logic          ask;
        ask = 1'b0;
        case (act)
            ACT_PROG_ENC: begin
                program_mode = step_mode(program_mode, PROGRAM_COUNT,
                                         quad_dir(prog_pins, {pa, pb}));
                prog_pins = {pa, pb};
                shown = DISP_PREVIEW;
                expire_at = '0;
            end
            ACT_PROG_BUTTON: begin
                if (({1'b0, effect_mode} + 7'd1) < EFFECT_COUNT) effect_mode = effect_mode + 6'd1;
                else effect_mode = '0;
                persist_due = 1'b1;
            end
            ACT_COLOR_ENC: begin
                color_mode = step_mode(color_mode, COLOR_MODE_COUNT,
                                       quad_dir(color_pins, {pa, pb}));
                color_pins = {pa, pb};
                shown = DISP_PALETTE;
                expire_at = now + {16'b0, panel_cfg.palette_hold_ms};
            end
            ACT_COLOR_BUTTON: begin
                color_mode = '0;
                shown = DISP_PREVIEW;
                expire_at = '0;
            end
            ACT_SPEED_KNOB, ACT_BRIGHT_KNOB: begin
                cur = (act == ACT_SPEED_KNOB) ? speed_lvl : bright_lvl;
                diff = (ks > cur) ? ks - cur : cur - ks;
                if (diff > panel_cfg.change_threshold) begin
                    if (act == ACT_SPEED_KNOB) begin
                        speed_lvl = ks;
                        shown = DISP_SPEED;
                    end else begin
                        bright_lvl = ks;
                        shown = DISP_BRIGHT;
                    end
                    expire_at = now + {16'b0, panel_cfg.default_hold_ms};
                end
            end
            default: ;
        endcase

        // Timeout: a temporary display whose expiry lies in the past half
        // of the modular clock falls back to the preview.
        since = now - expire_at;
        if (since != 32'd0 && !since[31]) shown = DISP_PREVIEW;

        // Fade-out before expiry on temporary displays, fade-in on preview.
        if (shown != DISP_PREVIEW) begin
            span = expire_at - now;
            win = panel_cfg.fade_out_ms;
        end else begin
            span = since;
            win = panel_cfg.fade_in_ms;
        end
        if (win != 16'd0 && span < {16'b0, win}) begin
            scaled = ({32'b0, span} * 64'd255) / {48'b0, win};
            r.fade_level = scaled[7:0];
        end else begin
            r.fade_level = LEVEL_FULL;
        end

        // Rate-limited save request.
        if (persist_due && (now - saved_at) > panel_cfg.persist_interval_ms) begin
            persist_due = 1'b0;
            saved_at = now;
            ask = 1'b1;
        end

        r.shown_display   = shown;
        r.program_index   = program_mode;
        r.color_index     = color_mode;
        r.effect_index    = effect_mode;
        r.speed_code      = speed_lvl;
        r.brightness_code = bright_lvl;
        r.persist_request = ask;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at %0t ns: %s expected 0x%0h observed 0x%0h",
                     $realtime, what, want, got);
    endtask

    // Offers one event after a random gap and records its prediction once
    // the transaction is accepted.
    task automatic send_item(logic [2:0] act, logic [31:0] now, logic pa, logic pb,
                             logic [11:0] ks);
        panel_event_t ev;
        int           gap;
        ev.now_ms = now;
        ev.pin_a = pa;
        ev.pin_b = pb;
        ev.knob_sample = ks;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, ev};
        s_tuser <= act;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_panel(act, now, pa, pb, ks));
    endtask

    // Stops offering input and waits until every predicted result has come.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes one register through a setup and an access phase, then reads it back.
    task automatic program_register(reg_index_t idx, logic [31:0] value);
        logic [31:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_THRESHOLD:    panel_cfg.change_threshold = value[11:0];
            REG_DEFAULT_HOLD: panel_cfg.default_hold_ms = value[15:0];
            REG_PALETTE_HOLD: panel_cfg.palette_hold_ms = value[15:0];
            REG_FADE_IN:      panel_cfg.fade_in_ms = value[15:0];
            REG_FADE_OUT:     panel_cfg.fade_out_ms = value[15:0];
            REG_PERSIST:      panel_cfg.persist_interval_ms = value;
            default: ;
        endcase
        @(posedge aclk);
        psel <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (readback !== value)
            report_mismatch("register readback", 64'(value), 64'(readback));
    endtask

    // Ticks and the spare event code right after reset.
    task automatic test_power_up();
        send_item(ACT_TICK, 32'd0, 1'b0, 1'b0, 12'h000);
        send_item(ACT_TICK, 32'd400, 1'b1, 1'b1, 12'hFFF);
        send_item(ACT_SPARE, 32'hFFFF_FFFF, 1'b1, 1'b1, 12'hFFF);
    endtask

    // Refused step down at the bottom, steps up on both encoders, color reset.
    task automatic test_encoders();
        send_item(ACT_PROG_ENC, 32'd1000, 1'b0, 1'b1, 12'h000);
        send_item(ACT_PROG_ENC, 32'd1010, 1'b0, 1'b0, 12'h000);
        send_item(ACT_PROG_ENC, 32'd1020, 1'b1, 1'b0, 12'h000);
        send_item(ACT_PROG_ENC, 32'd1030, 1'b0, 1'b0, 12'h000);
        send_item(ACT_COLOR_ENC, 32'd1040, 1'b1, 1'b0, 12'h000);
        send_item(ACT_COLOR_ENC, 32'd1050, 1'b0, 1'b0, 12'h000);
        send_item(ACT_COLOR_BUTTON, 32'd1500, 1'b0, 1'b0, 12'h000);
    endtask

    // Effect wrap on the program button, knob changes on both sides of the threshold.
    task automatic test_buttons_and_knobs();
        repeat (4) send_item(ACT_PROG_BUTTON, 32'd2000, 1'b0, 1'b0, 12'h000);
        send_item(ACT_SPEED_KNOB, 32'd20000, 1'b0, 1'b0, 12'd0);
        send_item(ACT_BRIGHT_KNOB, 32'd20050, 1'b0, 1'b0, 12'd3972);
        send_item(ACT_BRIGHT_KNOB, 32'd20100, 1'b0, 1'b0, 12'd3971);
    endtask

    // Fade-out window, the expiry instant, fade-in after timeout, zero windows.
    task automatic test_display_timeout();
        send_item(ACT_TICK, 32'd27000, 1'b0, 1'b0, 12'h000);
        send_item(ACT_TICK, 32'd28100, 1'b0, 1'b0, 12'h000);
        send_item(ACT_TICK, 32'd28600, 1'b0, 1'b0, 12'h000);
        send_item(ACT_TICK, 32'd40000, 1'b0, 1'b0, 12'h000);
        pause_until_drained();
        program_register(REG_FADE_IN, 32'd0);
        program_register(REG_FADE_OUT, 32'd0);
        send_item(ACT_SPEED_KNOB, 32'd41000, 1'b0, 1'b0, 12'hFFF);
        send_item(ACT_TICK, 32'd41001, 1'b0, 1'b0, 12'h000);
        send_item(ACT_TICK, 32'd60000, 1'b0, 1'b0, 12'h000);
        pause_until_drained();
        program_register(REG_FADE_IN, {16'b0, FADE_IN_RESET});
        program_register(REG_FADE_OUT, {16'b0, FADE_OUT_RESET});
        clock_ms = 32'd60000;
    endtask

    // The receiver holds off for a long stretch while events keep coming.
    task automatic test_backpressure();
        steady = 1'b1;
        hold_len = BACKLOG_CYCLES;
        repeat (24) send_item(3'($urandom_range(0, 6)), advance_clock(),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              12'($urandom_range(0, 4095)));
        steady = 1'b0;
        pause_until_drained();
    endtask

    // Random traffic under several register settings, extremes included.
    task automatic test_random_traffic();
        logic [31:0] vals[6];
        logic [7:0]  turn;
        logic [1:0]  pins;
        logic [2:0]  act;
        int          sent;
        int          roll;
        int          base;
        int          target;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: vals = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
                1: vals = '{32'd4095, 32'd65535, 32'd65535, 32'd65535, 32'd65535,
                            32'hFFFF_FFFF};
                2: vals = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1};
                3: vals = '{32'd123, 32'd8000, 32'd9000, 32'd1000, 32'd1500, 32'd10000};
                default: vals = '{$urandom_range(0, 400), $urandom_range(0, 20000),
                                  $urandom_range(0, 20000), $urandom_range(1, 3000),
                                  $urandom_range(1, 3000), $urandom_range(0, 30000)};
            endcase
            pause_until_drained();
            for (int i = 0; i < 6; i++) program_register(reg_index_t'(i), vals[i]);
            // One phase runs without gaps, the last one crosses the clock wrap.
            steady = (phase == 3);
            if (phase == 5) clock_ms = 32'hFFFF_0000;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 30) begin
                    // Whole detent on one encoder, now and then broken up.
                    act = $urandom_range(0, 1) ? ACT_PROG_ENC : ACT_COLOR_ENC;
                    turn = $urandom_range(0, 1) ? TURN_UP : TURN_DOWN;
                    for (int i = 0; i < 4; i++) begin
                        pins = turn[7 - 2 * i -: 2];
                        if ($urandom_range(0, 99) < 8) pins = 2'($urandom_range(0, 3));
                        if ($urandom_range(0, 99) < 10) begin
                            send_item(ACT_TICK, advance_clock(), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)),
                                      12'($urandom_range(0, 4095)));
                            sent++;
                        end
                        send_item(act, advance_clock(), pins[1], pins[0],
                                  12'($urandom_range(0, 4095)));
                        sent++;
                    end
                end else if (roll < 40) begin
                    send_item(ACT_PROG_BUTTON, advance_clock(), 1'b0, 1'b0, 12'h000);
                    sent++;
                end else if (roll < 45) begin
                    send_item(ACT_COLOR_BUTTON, advance_clock(), 1'b1, 1'b1, 12'hFFF);
                    sent++;
                end else if (roll < 70) begin
                    // Knob samples, half of them close to the change threshold.
                    act = $urandom_range(0, 1) ? ACT_SPEED_KNOB : ACT_BRIGHT_KNOB;
                    if ($urandom_range(0, 1)) begin
                        target = $urandom_range(0, 4095);
                    end else begin
                        base = (act == ACT_SPEED_KNOB) ? int'(speed_lvl) : int'(bright_lvl);
                        target = int'(panel_cfg.change_threshold) + $urandom_range(0, 2) - 1;
                        target = $urandom_range(0, 1) ? base + target : base - target;
                        if (target < 0) target = 0;
                        if (target > 4095) target = 4095;
                    end
                    send_item(act, advance_clock(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), target[11:0]);
                    sent++;
                end else if (roll < 88) begin
                    send_item(ACT_TICK, advance_clock(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                    sent++;
                end else if (roll < 95) begin
                    act = $urandom_range(0, 1) ? ACT_PROG_ENC : ACT_COLOR_ENC;
                    send_item(act, advance_clock(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                    sent++;
                end else if (roll < 98) begin
                    send_item(ACT_SPARE, advance_clock(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                    sent++;
                end else begin
                    // Fully random transaction, timestamp included.
                    send_item(3'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                    sent++;
                end
            end
            steady = 1'b0;
        end
    endtask

    // Receiver: random ready pattern, plus a long hold-off when one is requested.
    initial begin
        int stall;
        int burst;
        @(posedge aclk);
        forever begin
            if (hold_len > 0) begin
                stall = hold_len;
                hold_len = 0;
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                burst = $urandom_range(1, 8);
                repeat (burst) @(posedge aclk);
            end
        end
    end

    // Compares each output transaction with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            observed = panel_result_t'(m_tdata[52:0]);
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", 64'd0, {8'b0, m_tdata});
            end else begin
                predicted = expected_results.pop_front();
                if (observed.shown_display !== predicted.shown_display)
                    report_mismatch("shown_display", 64'(predicted.shown_display),
                                    64'(observed.shown_display));
                if (observed.fade_level !== predicted.fade_level)
                    report_mismatch("fade_level", 64'(predicted.fade_level),
                                    64'(observed.fade_level));
                if (observed.program_index !== predicted.program_index)
                    report_mismatch("program_index", 64'(predicted.program_index),
                                    64'(observed.program_index));
                if (observed.color_index !== predicted.color_index)
                    report_mismatch("color_index", 64'(predicted.color_index),
                                    64'(observed.color_index));
                if (observed.effect_index !== predicted.effect_index)
                    report_mismatch("effect_index", 64'(predicted.effect_index),
                                    64'(observed.effect_index));
                if (observed.speed_code !== predicted.speed_code)
                    report_mismatch("speed_code", 64'(predicted.speed_code),
                                    64'(observed.speed_code));
                if (observed.brightness_code !== predicted.brightness_code)
                    report_mismatch("brightness_code", 64'(predicted.brightness_code),
                                    64'(observed.brightness_code));
                if (observed.persist_request !== predicted.persist_request)
                    report_mismatch("persist_request", 64'(predicted.persist_request),
                                    64'(observed.persist_request));
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_power_up();
        test_encoders();
        test_buttons_and_knobs();
        test_display_timeout();
        test_backpressure();
        test_random_traffic();
        pause_until_drained();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
